// ===== sv/srec_pkg.sv =====
// ----------------------------------------------------------------------------
// srec_pkg: shared types and helpers of the S3 S-record encoder
// Command format between the front and the back, queue depth, and the
// character helpers used to build the record text.
// ----------------------------------------------------------------------------
`default_nettype none

package srec_pkg;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [7:0] RecMax      = 8'd250;
  localparam logic [7:0] CountExtra  = 8'd5;

  // register indexes of the configuration port
  localparam logic [1:0] RegRecordBytes = 2'd0;
  localparam logic [1:0] RegNoisePeriod = 2'd1;

  // one command per accepted item that produces text
  typedef struct packed {
    logic        is_start;  // S0 line
    logic        hdr;       // record opens with S3, count and address
    logic        csum_en;   // record closes after this byte
    logic        s7;        // S7 line closes the command
    logic [7:0]  cnt;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [7:0]  csum;
  } cmd_t;

  // output segments of the back sequencer
  typedef enum logic [4:0] {
    PH_S0   = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_DATA = 5'b00100,
    PH_CSUM = 5'b01000,
    PH_S7   = 5'b10000
  } phase_e;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = 8'h30 + {4'd0, nib};
    end else begin
      hex_char = 8'h37 + {4'd0, nib};
    end
  endfunction

  // "S0030000FC"
  function automatic logic [7:0] s0_char(input logic [3:0] idx);
    unique case (idx)
      4'd0:    s0_char = 8'h53;
      4'd1:    s0_char = 8'h30;
      4'd2:    s0_char = 8'h30;
      4'd3:    s0_char = 8'h33;
      4'd8:    s0_char = 8'h46;
      4'd9:    s0_char = 8'h43;
      default: s0_char = 8'h30;
    endcase
  endfunction

  // "S7060000000000F9"
  function automatic logic [7:0] s7_char(input logic [3:0] idx);
    unique case (idx)
      4'd0:    s7_char = 8'h53;
      4'd1:    s7_char = 8'h37;
      4'd3:    s7_char = 8'h36;
      4'd14:   s7_char = 8'h46;
      4'd15:   s7_char = 8'h39;
      default: s7_char = 8'h30;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/srecord_s3_encoder.sv =====
// ----------------------------------------------------------------------------
// srecord_s3_encoder: S3 S-record text encoder
// Turns a chunk of memory bytes into ASCII S0/S3/S7 record text, one
// character per output beat.
// ----------------------------------------------------------------------------
// A start beat (mode 0) opens a chunk and emits the S0 header line; each data
// beat (mode 1) emits its two upper-case hex digits, preceded by "S3", the
// count and the eight-digit address when it opens a record, and followed by
// the checksum when it closes one, and by the S7 line after the chunk's last
// byte. The front takes one input beat per cycle while the queue has room and
// turns it into a command in a four-entry queue; the back spells each command
// out into an output register at one character per cycle while that register
// is free or being popped. The output rate therefore sets the pace: a plain
// data byte spells 2 characters, a record-opening byte 14, a record-closing
// byte 4 (20 with the S7 line), and a start beat 10 (26 for an empty chunk).
// A burst of up to four beats is absorbed while earlier text drains. Data beats
// with no open chunk are taken and dropped silently. The configuration port
// is always ready; write it only while the block is idle. Register 0 is
// record_bytes (8 bits, reset 40), register 1 is noise_period (16 bits,
// reset 0); other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_s3_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // input queue side
  input  wire logic        push,
  output logic             full,
  input  wire logic        mode_i,
  input  wire logic [31:0] start_address_i,
  input  wire logic [15:0] chunk_length_i,
  input  wire logic [7:0]  data_byte_i,
  // result queue side
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       ascii_char_o,
  output logic             line_end_o,
  output logic             run_last_o
);

  srec_pkg::cmd_t front_cmd;
  srec_pkg::cmd_t head_cmd;
  logic           front_we;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // configuration never stalls
  assign cfg_ready_o = 1'b1;

  // hold input beats off while the command queue is full
  assign full = q_full;

  srec_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (push && !q_full),
    .mode_i          (mode_i),
    .start_address_i (start_address_i),
    .chunk_length_i  (chunk_length_i),
    .data_byte_i     (data_byte_i),
    .cmd_we_o        (front_we),
    .cmd_o           (front_cmd)
  );

  srec_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (front_we),
    .wr_cmd_i (front_cmd),
    .full_o   (q_full),
    .rd_en_i  (q_pop),
    .rd_cmd_o (head_cmd),
    .empty_o  (q_empty)
  );

  // spell out commands; the output register parts the result side
  srec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_cmd_i      (head_cmd),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .ascii_char_o (ascii_char_o),
    .line_end_o   (line_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

`default_nettype wire

// ===== sv/srec_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// srec_cmd_fifo: command queue between front and back
// Small flop-based FIFO; the head is visible while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module srec_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire srec_pkg::cmd_t wr_cmd_i,
  output logic               full_o,
  input  wire logic          rd_en_i,
  output srec_pkg::cmd_t     rd_cmd_o,
  output logic               empty_o
);

  srec_pkg::cmd_t mem_q [srec_pkg::QDepth];
  logic [srec_pkg::QPtrW:0] wr_ptr_q, wr_ptr_d;
  logic [srec_pkg::QPtrW:0] rd_ptr_q, rd_ptr_d;

  assign empty_o  = (wr_ptr_q == rd_ptr_q);
  assign full_o   = (wr_ptr_q[srec_pkg::QPtrW] != rd_ptr_q[srec_pkg::QPtrW]) &&
                    (wr_ptr_q[srec_pkg::QPtrW-1:0] == rd_ptr_q[srec_pkg::QPtrW-1:0]);
  assign rd_cmd_o = mem_q[rd_ptr_q[srec_pkg::QPtrW-1:0]];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_en_i && !full_o) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en_i && !empty_o) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !full_o) begin
      mem_q[wr_ptr_q[srec_pkg::QPtrW-1:0]] <= wr_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srec_front.sv =====
// ----------------------------------------------------------------------------
// srec_front: item intake and record bookkeeping
// Tracks address, remaining bytes, record fill and checksum, and turns each
// start item and each data item of an open chunk into one command for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module srec_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [15:0]    cfg_data_i,
  input  wire logic           accept_i,
  input  wire logic           mode_i,
  input  wire logic [31:0]    start_address_i,
  input  wire logic [15:0]    chunk_length_i,
  input  wire logic [7:0]     data_byte_i,
  output logic                cmd_we_o,
  output srec_pkg::cmd_t      cmd_o
);

  logic [7:0]  record_bytes_q;
  logic [15:0] noise_period_q;
  logic [31:0] next_address_q, next_address_d;
  logic [15:0] bytes_remaining_q, bytes_remaining_d;
  logic [7:0]  record_fill_q, record_fill_d;
  logic [7:0]  record_size_q, record_size_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [15:0] noise_count_q, noise_count_d;

  logic [7:0]  lim;
  logic [7:0]  size_hdr;
  logic [7:0]  size_eff;
  logic [7:0]  cnt;
  logic [7:0]  sum_hdr;
  logic [7:0]  sum_new;
  logic [7:0]  fill_new;
  logic [16:0] noise_inc;
  logic        header;
  logic        rec_end;
  logic        noise_hit;

  always_comb begin
    if (record_bytes_q == 8'd0) begin
      lim = 8'd1;
    end else if (record_bytes_q > srec_pkg::RecMax) begin
      lim = srec_pkg::RecMax;
    end else begin
      lim = record_bytes_q;
    end
    size_hdr  = (bytes_remaining_q < {8'd0, lim}) ? bytes_remaining_q[7:0] : lim;
    header    = (record_fill_q == 8'd0);
    size_eff  = header ? size_hdr : record_size_q;
    cnt       = size_hdr + srec_pkg::CountExtra;
    sum_hdr   = cnt + next_address_q[31:24] + next_address_q[23:16] +
                next_address_q[15:8] + next_address_q[7:0];
    sum_new   = (header ? sum_hdr : running_sum_q) + data_byte_i;
    fill_new  = record_fill_q + 8'd1;
    rec_end   = (fill_new >= size_eff);
    noise_inc = {1'b0, noise_count_q} + 17'd1;
    noise_hit = (noise_period_q != 16'd0) && (noise_inc > {1'b0, noise_period_q});
  end

  always_comb begin
    next_address_d    = next_address_q;
    bytes_remaining_d = bytes_remaining_q;
    record_fill_d     = record_fill_q;
    record_size_d     = record_size_q;
    running_sum_d     = running_sum_q;
    noise_count_d     = noise_count_q;
    cmd_we_o          = 1'b0;
    cmd_o             = '0;
    cmd_o.cnt         = cnt;
    cmd_o.addr        = next_address_q;
    cmd_o.data        = data_byte_i;
    cmd_o.csum        = ~(sum_new + {7'd0, noise_hit});
    if (accept_i) begin
      if (!mode_i) begin
        next_address_d    = start_address_i;
        bytes_remaining_d = chunk_length_i;
        record_fill_d     = 8'd0;
        record_size_d     = 8'd0;
        running_sum_d     = 8'd0;
        cmd_we_o          = 1'b1;
        cmd_o.is_start    = 1'b1;
        cmd_o.s7          = (chunk_length_i == 16'd0);
      end else if (bytes_remaining_q != 16'd0) begin
        next_address_d    = next_address_q + 32'd1;
        bytes_remaining_d = bytes_remaining_q - 16'd1;
        record_size_d     = size_eff;
        cmd_we_o          = 1'b1;
        cmd_o.hdr         = header;
        if (rec_end) begin
          record_fill_d = 8'd0;
          running_sum_d = 8'd0;
          cmd_o.csum_en = 1'b1;
          cmd_o.s7      = (bytes_remaining_q == 16'd1);
          if (noise_period_q != 16'd0) begin
            noise_count_d = noise_hit ? 16'd0 : noise_inc[15:0];
          end
        end else begin
          record_fill_d = fill_new;
          running_sum_d = sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_bytes_q    <= 8'd40;
      noise_period_q    <= 16'd0;
      next_address_q    <= '0;
      bytes_remaining_q <= '0;
      record_fill_q     <= '0;
      record_size_q     <= '0;
      running_sum_q     <= '0;
      noise_count_q     <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == srec_pkg::RegRecordBytes)) begin
        record_bytes_q <= cfg_data_i[7:0];
      end
      if (cfg_we_i && (cfg_index_i == srec_pkg::RegNoisePeriod)) begin
        noise_period_q <= cfg_data_i;
      end
      next_address_q    <= next_address_d;
      bytes_remaining_q <= bytes_remaining_d;
      record_fill_q     <= record_fill_d;
      record_size_q     <= record_size_d;
      running_sum_q     <= running_sum_d;
      noise_count_q     <= noise_count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srec_back.sv =====
// ----------------------------------------------------------------------------
// srec_back: character sequencer
// Walks each command through its text segments into an output register, one
// character per cycle while that register is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module srec_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire srec_pkg::cmd_t q_cmd_i,
  input  wire logic           q_empty_i,
  output logic                q_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [7:0]          ascii_char_o,
  output logic                line_end_o,
  output logic                run_last_o
);

  srec_pkg::cmd_t  cmd_q;
  srec_pkg::phase_e phase_q, phase_next, phase_first;
  logic [3:0]      idx_q;
  logic            busy_q;
  logic            out_valid_q;
  logic [7:0]      char_q;
  logic            line_end_q;
  logic            run_last_q;

  logic            emit;
  logic            phase_last;
  logic            finish;     // no segment follows the current one
  logic            cmd_done;
  logic            load;
  logic [7:0]      ch;
  logic            le;
  logic [2:0]      nib_sel;
  logic [3:0]      addr_nib;

  assign nib_sel  = 3'(4'd11 - idx_q);
  assign addr_nib = 4'(cmd_q.addr >> {nib_sel, 2'b00});

  always_comb begin
    phase_last = 1'b0;
    phase_next = srec_pkg::PH_S7;
    finish     = 1'b1;
    ch         = 8'h30;
    le         = 1'b0;
    unique case (phase_q)
      srec_pkg::PH_S0: begin
        phase_last = (idx_q == 4'd9);
        ch         = srec_pkg::s0_char(idx_q);
        le         = phase_last;
        finish     = !cmd_q.s7;
      end
      srec_pkg::PH_HDR: begin
        phase_last = (idx_q == 4'd11);
        phase_next = srec_pkg::PH_DATA;
        finish     = 1'b0;
        if (idx_q == 4'd0) begin
          ch = 8'h53;
        end else if (idx_q == 4'd1) begin
          ch = 8'h33;
        end else if (idx_q == 4'd2) begin
          ch = srec_pkg::hex_char(cmd_q.cnt[7:4]);
        end else if (idx_q == 4'd3) begin
          ch = srec_pkg::hex_char(cmd_q.cnt[3:0]);
        end else begin
          ch = srec_pkg::hex_char(addr_nib);
        end
      end
      srec_pkg::PH_DATA: begin
        phase_last = (idx_q == 4'd1);
        phase_next = srec_pkg::PH_CSUM;
        finish     = !cmd_q.csum_en;
        ch         = srec_pkg::hex_char(idx_q[0] ? cmd_q.data[3:0] : cmd_q.data[7:4]);
      end
      srec_pkg::PH_CSUM: begin
        phase_last = (idx_q == 4'd1);
        finish     = !cmd_q.s7;
        ch         = srec_pkg::hex_char(idx_q[0] ? cmd_q.csum[3:0] : cmd_q.csum[7:4]);
        le         = phase_last;
      end
      srec_pkg::PH_S7: begin
        phase_last = (idx_q == 4'd15);
        ch         = srec_pkg::s7_char(idx_q);
        le         = phase_last;
      end
      default: begin
        phase_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (q_cmd_i.is_start) begin
      phase_first = srec_pkg::PH_S0;
    end else if (q_cmd_i.hdr) begin
      phase_first = srec_pkg::PH_HDR;
    end else begin
      phase_first = srec_pkg::PH_DATA;
    end
  end

  // advance when the output register is free or being drained this cycle
  assign emit     = busy_q && (!out_valid_q || pop_i);
  assign cmd_done = emit && phase_last && finish;
  assign load     = (!busy_q || cmd_done) && !q_empty_i;
  assign q_pop_o  = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= srec_pkg::PH_S0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q  <= 1'b1;
        phase_q <= phase_first;
        idx_q   <= '0;
      end else if (cmd_done) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        if (phase_last) begin
          phase_q <= phase_next;
          idx_q   <= '0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= q_cmd_i;
    end
    if (emit) begin
      char_q     <= ch;
      line_end_q <= le;
      run_last_q <= phase_last && finish;
    end
  end

  assign empty_o      = !out_valid_q;
  assign ascii_char_o = char_q;
  assign line_end_o   = line_end_q;
  assign run_last_o   = run_last_q;

endmodule

`default_nettype wire
